FILE: rtl/core/row_dispersion_index_assert.svh
// Assertion macros shared by the row dispersion index RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef ROW_DISPERSION_INDEX_ASSERT_SVH
`define ROW_DISPERSION_INDEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDI_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rdi: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define RDI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rdi: next-cycle implication failed");

`endif

FILE: rtl/core/rdi_pkg.sv
// Package for the row dispersion index block: widths, register indexes and
// the command and status structs between controller and datapath. No dependencies.
package rdi_pkg;

  // Sizing of the row buffer and the sample path.
  localparam int BOOT_MAX  = 1024;
  localparam int SAMPLE_W  = 24;
  localparam int ADDR_W    = $clog2(BOOT_MAX);
  localparam int CNT_W     = $clog2(BOOT_MAX + 1);
  localparam int SUM_W     = SAMPLE_W + ADDR_W;
  localparam int DEV_W     = 2 * SAMPLE_W + ADDR_W;
  localparam int DIV_CNT_W = $clog2(DEV_W + 1);

  // Fixed field and register widths.
  localparam int ROW_W      = 24;
  localparam int OUT_W      = 48;
  localparam int BOOT_CFG_W = 11;
  localparam int ROWS_CFG_W = 25;
  localparam int CFG_W      = 25;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

  // Reset values and limits of the registers.
  localparam logic [BOOT_CFG_W-1:0] BOOT_RESET = 11'd100;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 25'd2;
  localparam logic [ROWS_CFG_W-1:0] ROWS_LIMIT = 25'h1000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // a sample transaction completes this cycle
    logic div_start;  // launch the serial divider
    logic div_disp;   // divider run is the final quotient, not the mean
    logic mean_load;  // capture the mean and clear the scan state
    logic scan_rd;    // read the next buffer entry
    logic load_out;   // move the finished row into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_end;    // the sample on offer closes the row
    logic mean_zero;  // the captured mean is zero
    logic scan_last;  // this read is the final entry of the row
    logic pipe_empty; // no squared deviation still in flight
    logic div_done;   // divider quotient is final
    logic out_free;   // output register can take a new result
  } sts_t;

endpackage

FILE: rtl/core/rdi_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
module rdi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rdi_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the mean and
// the final quotient. Depends on rdi_pkg.
module rdi_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         disp_mode,
  input  logic [rdi_pkg::DEV_W-1:0]    dividend,
  input  logic [rdi_pkg::SAMPLE_W-1:0] divisor,
  output logic [rdi_pkg::DEV_W-1:0]    quotient,
  output logic                         done
);
  import rdi_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [SAMPLE_W-1:0]  rem;
  logic [SAMPLE_W-1:0]  dvs;
  logic [DEV_W-1:0]     quo;
  logic [SAMPLE_W:0]    rem_sh;
  logic [SAMPLE_W:0]    rem_diff;
  logic                 fits;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh   = {rem, quo[DEV_W-1]};
    fits     = (rem_sh >= {1'b0, dvs});
    rem_diff = rem_sh - {1'b0, dvs};
  end

  // Step counter and completion pulse. A mean run starts with the sum in the
  // top bits, so it needs only as many steps as the sum is wide.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (start) begin
        cnt <= disp_mode ? DIV_CNT_W'(DEV_W) : DIV_CNT_W'(SUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      quo <= {quo[DEV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/core/rdi_dp.sv
// Datapath of the row dispersion index: configuration registers, row buffer,
// sums, deviation pipeline, divider and output register. Depends on rdi_pkg,
// rdi_ram, rdi_div and row_dispersion_index_assert.svh.
`include "row_dispersion_index_assert.svh"

module rdi_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdi_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rdi_pkg::SAMPLE_W-1:0]   sample,
  input  rdi_pkg::cmd_t                  cmd,
  output rdi_pkg::sts_t                  sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [rdi_pkg::ROW_W-1:0]      row_index,
  output logic [rdi_pkg::OUT_W-1:0]      dispersion,
  output logic                           zero_mean,
  output logic                           saturated,
  output logic                           last_row
);
  import rdi_pkg::*;

  logic [BOOT_CFG_W-1:0] boot_count;
  logic [ROWS_CFG_W-1:0] row_count;
  logic [CNT_W-1:0]      eff_boot;
  logic [ROWS_CFG_W-1:0] eff_rows;

  logic [CNT_W-1:0]      sample_counter;
  logic [CNT_W-1:0]      len;
  logic [SUM_W-1:0]      running_sum;
  logic [ROW_W-1:0]      row_counter;
  logic [SAMPLE_W-1:0]   mean;
  logic [DEV_W-1:0]      deviation_sum;
  logic                  is_last;

  logic [ADDR_W-1:0]     scan_addr;
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  rd_vld;
  logic [SAMPLE_W-1:0]   diff;
  logic                  diff_vld;
  logic [2*SAMPLE_W-1:0] sq;
  logic                  sq_vld;

  logic [DEV_W-1:0]      div_dividend;
  logic [SAMPLE_W-1:0]   div_divisor;
  logic [DEV_W-1:0]      div_quo;
  logic                  div_done;
  logic                  quo_ovf;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_count <= BOOT_RESET;
      row_count  <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOOT_COUNT: boot_count <= cfg_data[BOOT_CFG_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their legal ranges.
  always_comb begin
    if (32'(boot_count) < 32'd2) begin
      eff_boot = CNT_W'(2);
    end else if (32'(boot_count) > 32'(BOOT_MAX)) begin
      eff_boot = CNT_W'(BOOT_MAX);
    end else begin
      eff_boot = CNT_W'(boot_count);
    end
    if (row_count < ROWS_CFG_W'(2)) begin
      eff_rows = ROWS_CFG_W'(2);
    end else if (row_count > ROWS_LIMIT) begin
      eff_rows = ROWS_LIMIT;
    end else begin
      eff_rows = row_count;
    end
  end

  // Row buffer: written on sample transactions, read during the scan.
  rdi_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BOOT_MAX)
  ) u_buf (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(sample_counter[ADDR_W-1:0]),
    .wdata(sample),
    .raddr(scan_addr),
    .rdata(rd_data)
  );

  // Sample count, row length and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      running_sum    <= '0;
      row_counter    <= '0;
    end else if (cmd.accept) begin
      running_sum <= running_sum + SUM_W'(sample);
      if (!sts.row_end) begin
        sample_counter <= sample_counter + CNT_W'(1);
      end
    end else if (cmd.load_out) begin
      sample_counter <= '0;
      running_sum    <= '0;
      row_counter    <= is_last ? '0 : row_counter + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.row_end) begin
      len <= sample_counter + CNT_W'(1);
    end
  end

  // Scan address and the mean.
  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean      <= div_quo[SAMPLE_W-1:0];
      scan_addr <= '0;
    end else if (cmd.scan_rd) begin
      scan_addr <= scan_addr + ADDR_W'(1);
    end
  end

  // Deviation pipeline: read, absolute difference, square, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      diff_vld <= 1'b0;
      sq_vld   <= 1'b0;
    end else begin
      rd_vld   <= cmd.scan_rd;
      diff_vld <= rd_vld;
      sq_vld   <= diff_vld;
    end
  end

  always_ff @(posedge clk) begin
    diff <= (rd_data >= mean) ? rd_data - mean : mean - rd_data;
    sq   <= diff * diff;
    if (cmd.mean_load) begin
      deviation_sum <= '0;
    end else if (sq_vld) begin
      deviation_sum <= deviation_sum + DEV_W'(sq);
    end
  end

  // Shared divider: the mean first, then the deviation sum over the mean.
  always_comb begin
    if (cmd.div_disp) begin
      div_dividend = deviation_sum;
      div_divisor  = mean;
    end else begin
      div_dividend = {running_sum, SAMPLE_W'(0)};
      div_divisor  = SAMPLE_W'(len);
    end
  end

  rdi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .disp_mode(cmd.div_disp),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign quo_ovf = (div_quo[DEV_W-1:OUT_W] != '0);
  assign is_last = ({1'b0, row_counter} + ROWS_CFG_W'(1)) >= eff_rows;

  // Output register; it is refilled only once its transaction has completed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      row_index <= row_counter;
      last_row  <= is_last;
      zero_mean <= sts.mean_zero;
      if (sts.mean_zero) begin
        dispersion <= '0;
        saturated  <= 1'b0;
      end else begin
        dispersion <= quo_ovf ? '1 : div_quo[OUT_W-1:0];
        saturated  <= quo_ovf;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.row_end    = (sample_counter + CNT_W'(1)) >= eff_boot;
    sts.mean_zero  = (mean == '0);
    sts.scan_last  = (CNT_W'(scan_addr) + CNT_W'(1)) == len;
    sts.pipe_empty = !rd_vld && !diff_vld && !sq_vld;
    sts.div_done   = div_done;
    sts.out_free   = !out_valid || out_ready;
  end

  // The scan stays inside the entries written in this row.
  `RDI_ASSERT_IMPLIES(a_scan_in_row, clk, rst, cmd.scan_rd, (CNT_W'(scan_addr) < len))
  // A result is never written over one that has not been taken.
  `RDI_ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.load_out, (!out_valid || out_ready))
  // The mean is captured only from a finished division.
  `RDI_ASSERT_IMPLIES(a_mean_from_div, clk, rst, cmd.mean_load, div_done)
  // New samples never land while deviations of the row are still in flight.
  `RDI_ASSERT_IMPLIES(a_accept_idle_pipe, clk, rst, cmd.accept, (sts.pipe_empty && !sq_vld))
  // A loaded result is presented in the next cycle.
  `RDI_ASSERT_NEXT(a_out_presented, clk, rst, cmd.load_out, out_valid)

endmodule

FILE: rtl/core/rdi_ctrl.sv
// Controller of the row dispersion index: sequences sample intake, the mean,
// the deviation scan, the final division and the result hand-off. Depends on rdi_pkg.
module rdi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rdi_pkg::sts_t sts,
  output rdi_pkg::cmd_t cmd
);
  import rdi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MSTART = 9'b000000010,
    S_MWAIT  = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_DRAIN  = 9'b000100000,
    S_DSTART = 9'b001000000,
    S_DWAIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.row_end) begin
          state_next = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.mean_zero ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_disp  = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/row_dispersion_index.sv
// Row dispersion index top level: joins rdi_ctrl and rdi_dp; depends on rdi_pkg.
// Samples are taken one per cycle while a row fills. After the row's closing sample,
// the block runs the 34-step mean division and, unless the mean is zero, a row scan
// through a 3-stage square pipeline and the 58-step final division. The result is
// presented once the output register is free; samples are taken again from then on.
// Synchronous reset clears control state and registers; the row buffer is not cleared.
module row_dispersion_index (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rdi_pkg::SAMPLE_W-1:0]  sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdi_pkg::ROW_W-1:0]     row_index,
  output logic [rdi_pkg::OUT_W-1:0]     dispersion,
  output logic                          zero_mean,
  output logic                          saturated,
  output logic                          last_row
);
  import rdi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  rdi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Storage and arithmetic.
  rdi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .row_index (row_index),
    .dispersion(dispersion),
    .zero_mean (zero_mean),
    .saturated (saturated),
    .last_row  (last_row)
  );

endmodule
